// File: sv/tlepc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlepc_pkg
// Shared constants and types of the two-level event pending controller.
// ----------------------------------------------------------------------------
package tlepc_pkg;

  localparam int unsigned WORD_BITS  = 64;  // power of two
  localparam int unsigned NUM_VCPUS  = 8;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned PORT_W     = 12;
  localparam int unsigned VCPU_W     = 3;

  localparam int unsigned WORD_IDX_W = $clog2(WORD_BITS);
  localparam int unsigned CPU_IDX_W  = (NUM_VCPUS > 1) ? $clog2(NUM_VCPUS) : 1;
  localparam int unsigned NUM_PORTS  = WORD_BITS * WORD_BITS;
  localparam int unsigned ROW_W      = 2 * WORD_BITS;  // pending and mask words

  localparam logic [OPCODE_W-1:0] OP_SET_PENDING    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR_PENDING  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_UNMASK         = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_QUERY          = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_MASK           = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR_SELECTOR = 3'd5;

  typedef struct packed {
    logic                  en;
    logic                  set;
    logic                  clr;
    logic [CPU_IDX_W-1:0]  cpu;
    logic [WORD_IDX_W-1:0] word;
  } sel_cmd_t;

  typedef struct packed {
    logic                 raised;
    logic [WORD_BITS-1:0] sel_after;
    logic                 flag_after;
  } sel_stat_t;

endpackage

// File: sv/two_level_event_pending_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_event_pending_controller_top
// Pending and mask bitmaps per event port, selector word and upcall flag
// per processor; one result per operation.
// ----------------------------------------------------------------------------
// Each transaction reads the pending and mask words of the port from one
// synchronous bitmap RAM when it is accepted; they are then modified and
// written back, while the selector bank is updated and the result is loaded
// into the output register. One operation is in flight at a time; a new one
// is taken the cycle after write-back. A full
// output register that is not drained stalls write-back. Bitmap rows carry
// valid bits cleared at reset, so no clearing pass is needed.
module two_level_event_pending_controller_top
  import tlepc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [PORT_W-1:0]   port_i,
  input  logic [VCPU_W-1:0]   vcpu_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                was_pending_o,
  output logic                was_masked_o,
  output logic                upcall_raised_o,
  output logic                poll_check_o,
  output logic [63:0]         selector_word_o,
  output logic                upcall_flag_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                state_q;
  logic [OPCODE_W-1:0]   op_q;
  logic [WORD_IDX_W-1:0] word_q;
  logic [WORD_IDX_W-1:0] bit_q;
  logic [CPU_IDX_W-1:0]  cpu_q;
  logic                  port_ok_q;
  logic                  cpu_ok_q;
  logic [WORD_BITS-1:0]  row_valid_q;

  logic                  out_valid_q;
  logic                  was_pending_q;
  logic                  was_masked_q;
  logic                  raised_q;
  logic                  poll_q;
  logic [WORD_BITS-1:0]  sel_word_q;
  logic                  flag_q;

  logic                  accept;
  logic                  commit;
  logic [WORD_IDX_W-1:0] in_word;
  logic [ROW_W-1:0]      rdata;
  logic [ROW_W-1:0]      row_cur;
  logic [ROW_W-1:0]      row_d;
  logic [WORD_BITS-1:0]  pend_w;
  logic [WORD_BITS-1:0]  mask_w;
  logic [WORD_BITS-1:0]  pend_d;
  logic [WORD_BITS-1:0]  mask_d;
  logic [WORD_BITS-1:0]  pbit;
  logic                  was_p;
  logic                  was_m;
  logic                  notify;
  logic                  poll;
  logic                  live;
  sel_cmd_t              sel_cmd;
  sel_stat_t             sel_stat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign in_word    = WORD_IDX_W'(port_i >> WORD_IDX_W);

  tlepc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(WORD_BITS)
  ) u_bitmap_ram (
    .clk_i  (clk_i),
    .we_i   (commit && live),
    .waddr_i(word_q),
    .wdata_i(row_d),
    .re_i   (accept),
    .raddr_i(in_word),
    .rdata_o(rdata)
  );

  always_comb begin
    live    = port_ok_q && cpu_ok_q;
    row_cur = row_valid_q[word_q] ? rdata : '0;
    pend_w  = row_cur[WORD_BITS-1:0];
    mask_w  = row_cur[ROW_W-1:WORD_BITS];
    pbit    = WORD_BITS'(1) << bit_q;
    was_p   = port_ok_q && ((pend_w & pbit) != '0);
    was_m   = !port_ok_q || ((mask_w & pbit) != '0);
    pend_d  = pend_w;
    mask_d  = mask_w;
    notify  = 1'b0;
    poll    = 1'b0;
    unique case (op_q)
      OP_SET_PENDING: begin
        pend_d = pend_w | pbit;
        poll   = live && !was_p;
        notify = live && !was_p && !was_m;
      end
      OP_CLEAR_PENDING: pend_d = pend_w & ~pbit;
      OP_UNMASK: begin
        mask_d = mask_w & ~pbit;
        notify = live && was_p && was_m;
      end
      OP_MASK: mask_d = mask_w | pbit;
      default: ;
    endcase
    row_d = {mask_d, pend_d};

    sel_cmd.en   = commit && live;
    sel_cmd.set  = notify;
    sel_cmd.clr  = live && (op_q == OP_CLEAR_SELECTOR);
    sel_cmd.cpu  = cpu_q;
    sel_cmd.word = word_q;
  end

  tlepc_sel_bank u_sel_bank (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (sel_cmd),
    .stat_o(sel_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      row_valid_q   <= '0;
      was_pending_q <= 1'b0;
      was_masked_q  <= 1'b0;
      raised_q      <= 1'b0;
      poll_q        <= 1'b0;
      sel_word_q    <= '0;
      flag_q        <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_q <= ST_IDLE;
            if (live) begin
              row_valid_q[word_q] <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (commit) begin
        out_valid_q   <= 1'b1;
        was_pending_q <= was_p;
        was_masked_q  <= was_m;
        raised_q      <= notify && sel_stat.raised;
        poll_q        <= poll;
        sel_word_q    <= cpu_ok_q ? sel_stat.sel_after : '0;
        flag_q        <= cpu_ok_q && sel_stat.flag_after;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= opcode_i;
      word_q    <= in_word;
      bit_q     <= port_i[WORD_IDX_W-1:0];
      cpu_q     <= CPU_IDX_W'(vcpu_i);
      port_ok_q <= (32'(port_i) < NUM_PORTS);
      cpu_ok_q  <= (32'(vcpu_i) < NUM_VCPUS);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign was_pending_o   = was_pending_q;
  assign was_masked_o    = was_masked_q;
  assign upcall_raised_o = raised_q;
  assign poll_check_o    = poll_q;
  assign selector_word_o = 64'(sel_word_q);
  assign upcall_flag_o   = flag_q;

endmodule

// File: sv/tlepc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlepc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tlepc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tlepc_sel_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlepc_sel_bank
// Per-processor selector words and upcall flags, with notify and
// acknowledge updates.
// ----------------------------------------------------------------------------
module tlepc_sel_bank
  import tlepc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sel_cmd_t  cmd_i,
  output sel_stat_t stat_o
);

  logic [WORD_BITS-1:0] sel_q [NUM_VCPUS];
  logic [NUM_VCPUS-1:0] flag_q;

  logic [WORD_BITS-1:0] sel_cur;
  logic [WORD_BITS-1:0] sbit;
  logic                 flag_cur;
  logic [WORD_BITS-1:0] sel_d;
  logic                 flag_d;
  logic                 newly_set;

  always_comb begin
    sel_cur   = sel_q[cmd_i.cpu];
    flag_cur  = flag_q[cmd_i.cpu];
    sbit      = WORD_BITS'(1) << cmd_i.word;
    newly_set = cmd_i.set && ((sel_cur & sbit) == '0);
    sel_d     = sel_cur;
    flag_d    = flag_cur;
    if (cmd_i.set) begin
      sel_d = sel_cur | sbit;
      if (newly_set) begin
        flag_d = 1'b1;
      end
    end else if (cmd_i.clr) begin
      sel_d  = sel_cur & ~sbit;
      flag_d = 1'b0;
    end
    stat_o.raised     = newly_set && !flag_cur;
    stat_o.sel_after  = sel_d;
    stat_o.flag_after = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VCPUS; i++) begin
        sel_q[i] <= '0;
      end
      flag_q <= '0;
    end else if (cmd_i.en) begin
      sel_q[cmd_i.cpu]  <= sel_d;
      flag_q[cmd_i.cpu] <= flag_d;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the two-level event pending controller against an in-bench model.
// ----------------------------------------------------------------------------
// A directed run covers the edges of the port and processor ranges, every
// opcode and the selector and upcall corner cases. A random run follows:
// mostly mask/set/unmask/acknowledge and set/query/clear sequences on a small pool of ports,
// with some noise. Each accepted transaction is predicted and the expected
// result is queued; each returned result is compared field by field with
// the oldest one. Both sides stall at random, with one stall-free stretch and one
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import tlepc_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

  localparam int unsigned N_RANDOM     = 500;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_START   = 300;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned CALM_FIRST   = 600;
  localparam int unsigned CALM_LAST    = 900;
  localparam int unsigned MAX_PRINTS   = 20;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PORT_W-1:0]   port;
    logic [VCPU_W-1:0]   vcpu;
  } evt_op_t;

  typedef struct packed {
    logic        was_pending;
    logic        was_masked;
    logic        upcall_raised;
    logic        poll_check;
    logic [63:0] selector_word;
    logic        upcall_flag;
  } evt_res_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [OPCODE_W-1:0] opcode_i    = '0;
  logic [PORT_W-1:0]   port_i      = '0;
  logic [VCPU_W-1:0]   vcpu_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                was_pending_o;
  logic                was_masked_o;
  logic                upcall_raised_o;
  logic                poll_check_o;
  logic [63:0]         selector_word_o;
  logic                upcall_flag_o;

  two_level_event_pending_controller_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .port_i          (port_i),
    .vcpu_i          (vcpu_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .was_pending_o   (was_pending_o),
    .was_masked_o    (was_masked_o),
    .upcall_raised_o (upcall_raised_o),
    .poll_check_o    (poll_check_o),
    .selector_word_o (selector_word_o),
    .upcall_flag_o   (upcall_flag_o)
  );

  // model state
  logic [WORD_BITS-1:0] pend_bm  [WORD_BITS];
  logic [WORD_BITS-1:0] mask_bm  [WORD_BITS];
  logic [WORD_BITS-1:0] sel_reg  [NUM_VCPUS];
  logic                 upcall_q [NUM_VCPUS];

  evt_op_t  op_q[$];
  evt_res_t result_q[$];
  evt_op_t  next_op;
  evt_res_t got_res;
  evt_res_t want_res;

  logic        in_taken   = 1'b0;
  int unsigned cyc        = 0;
  int unsigned quiet_cyc  = 0;
  int unsigned hold_left  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_upcalls  = 0;
  int unsigned n_polls    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic calm_phase();
    return (cyc >= CALM_FIRST) && (cyc <= CALM_LAST);
  endfunction

  // sets a word's selector bit; returns 1 when the upcall flag rises
  function automatic logic mark_word(int unsigned cpu, int unsigned word);
    if (sel_reg[cpu][word]) return 1'b0;
    sel_reg[cpu][word] = 1'b1;
    if (upcall_q[cpu]) return 1'b0;
    upcall_q[cpu] = 1'b1;
    return 1'b1;
  endfunction

  function automatic evt_res_t predict_event(evt_op_t op);
    evt_res_t    r;
    logic        port_ok;
    logic        cpu_ok;
    int unsigned word;
    int unsigned bit_idx;
    r            = '0;
    r.was_masked = 1'b1;
    port_ok      = int'(op.port) < NUM_PORTS;
    cpu_ok       = int'(op.vcpu) < NUM_VCPUS;
    word         = op.port / WORD_BITS;
    bit_idx      = op.port % WORD_BITS;
    if (port_ok) begin
      r.was_pending = pend_bm[word][bit_idx];
      r.was_masked  = mask_bm[word][bit_idx];
    end
    if (port_ok && cpu_ok) begin
      case (op.opcode)
        OP_SET_PENDING: begin
          if (!r.was_pending) begin
            pend_bm[word][bit_idx] = 1'b1;
            r.poll_check = 1'b1;
            if (!r.was_masked) r.upcall_raised = mark_word(op.vcpu, word);
          end
        end
        OP_CLEAR_PENDING: pend_bm[word][bit_idx] = 1'b0;
        OP_UNMASK: begin
          mask_bm[word][bit_idx] = 1'b0;
          if (r.was_masked && r.was_pending) r.upcall_raised = mark_word(op.vcpu, word);
        end
        OP_MASK: mask_bm[word][bit_idx] = 1'b1;
        OP_CLEAR_SELECTOR: begin
          sel_reg[op.vcpu][word] = 1'b0;
          upcall_q[op.vcpu]      = 1'b0;
        end
        default: ;
      endcase
    end
    if (cpu_ok) begin
      r.selector_word = 64'(sel_reg[op.vcpu]);
      r.upcall_flag   = upcall_q[op.vcpu];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
  endtask

  task automatic add_op(logic [OPCODE_W-1:0] opc, int unsigned port, int unsigned vcpu);
    evt_op_t op;
    op.opcode = opc;
    op.port   = PORT_W'(port);
    op.vcpu   = VCPU_W'(vcpu);
    op_q.push_back(op);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (op_q.size() != 0 && (calm_phase() || $urandom_range(99) >= 20)) begin
        next_op = op_q.pop_front();
        in_valid_i <= 1'b1;
        opcode_i   <= next_op.opcode;
        port_i     <= next_op.port;
        vcpu_i     <= next_op.vcpu;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cyc == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm_phase() || ($urandom_range(99) >= 20);
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        result_q.push_back(predict_event({opcode_i, port_i, vcpu_i}));
        n_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        got_res = {was_pending_o, was_masked_o, upcall_raised_o, poll_check_o,
                   selector_word_o, upcall_flag_o};
        n_upcalls += upcall_raised_o;
        n_polls   += poll_check_o;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(got_res.was_pending), 64'd0);
        end else begin
          want_res = result_q.pop_front();
          n_checked++;
          if (got_res.was_pending !== want_res.was_pending)
            report_mismatch("was_pending", 64'(got_res.was_pending),
                            64'(want_res.was_pending));
          if (got_res.was_masked !== want_res.was_masked)
            report_mismatch("was_masked", 64'(got_res.was_masked),
                            64'(want_res.was_masked));
          if (got_res.upcall_raised !== want_res.upcall_raised)
            report_mismatch("upcall_raised", 64'(got_res.upcall_raised),
                            64'(want_res.upcall_raised));
          if (got_res.poll_check !== want_res.poll_check)
            report_mismatch("poll_check", 64'(got_res.poll_check),
                            64'(want_res.poll_check));
          if (got_res.selector_word !== want_res.selector_word)
            report_mismatch("selector_word", got_res.selector_word,
                            want_res.selector_word);
          if (got_res.upcall_flag !== want_res.upcall_flag)
            report_mismatch("upcall_flag", 64'(got_res.upcall_flag),
                            64'(want_res.upcall_flag));
        end
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  initial begin
    int unsigned n_directed;
    int unsigned hot [12];
    int unsigned p;
    int unsigned v;
    int unsigned pick;

    for (int i = 0; i < WORD_BITS; i++) begin
      pend_bm[i] = '0;
      mask_bm[i] = '0;
    end
    for (int i = 0; i < NUM_VCPUS; i++) begin
      sel_reg[i]  = '0;
      upcall_q[i] = 1'b0;
    end

    // directed
    add_op(OP_SET_PENDING,    0,    0);  // fresh: raise and poll
    add_op(OP_SET_PENDING,    0,    0);  // already pending
    add_op(OP_SET_PENDING,    1,    0);  // selector bit already set
    add_op(OP_SET_PENDING,    4095, 7);  // top word, top processor
    add_op(OP_QUERY,          4095, 7);
    add_op(OP_RSVD6,          4095, 7);
    add_op(OP_RSVD7,          2730, 5);
    add_op(OP_MASK,           100,  3);
    add_op(OP_SET_PENDING,    100,  3);  // masked: poll only
    add_op(OP_UNMASK,         100,  3);  // masked and pending: raise
    add_op(OP_SET_PENDING,    320,  3);  // new selector bit, flag already up
    add_op(OP_CLEAR_SELECTOR, 100,  3);
    add_op(OP_CLEAR_SELECTOR, 100,  3);
    add_op(OP_UNMASK,         1365, 2);  // neither masked nor pending
    add_op(OP_SET_PENDING,    1365, 2);
    add_op(OP_UNMASK,         1365, 2);  // pending but not masked
    add_op(OP_MASK,           0,    0);
    add_op(OP_UNMASK,         0,    0);  // selector bit already set
    add_op(OP_CLEAR_PENDING,  0,    0);
    add_op(OP_QUERY,          0,    0);
    add_op(OP_CLEAR_PENDING,  2730, 5);
    add_op(OP_SET_PENDING,    2730, 5);
    add_op(OP_CLEAR_SELECTOR, 2730, 5);
    n_directed = op_q.size();

    // random: sequences on a small port pool, plus noise
    for (int i = 0; i < 12; i++) hot[i] = $urandom_range(NUM_PORTS - 1);
    while (op_q.size() < n_directed + N_RANDOM) begin
      pick = $urandom_range(99);
      p    = hot[$urandom_range(11)];
      v    = $urandom_range(NUM_VCPUS - 1);
      if (pick < 60) begin
        case ($urandom_range(2))
          0: begin
            add_op(OP_MASK, p, v);
            add_op(OP_SET_PENDING, p, v);
            add_op(OP_UNMASK, p, v);
            add_op(OP_CLEAR_SELECTOR, p, v);
          end
          1: begin
            add_op(OP_SET_PENDING, p, v);
            add_op(OP_QUERY, p, v);
            add_op(OP_CLEAR_PENDING, p, v);
            add_op(OP_SET_PENDING, p, v);
          end
          default: begin
            add_op(OP_CLEAR_SELECTOR, p, v);
            add_op(OP_SET_PENDING, p, v);
            add_op(OP_SET_PENDING, p, $urandom_range(NUM_VCPUS - 1));
          end
        endcase
      end else if (pick < 85) begin
        add_op(OPCODE_W'($urandom_range(7)), p, v);
      end else begin
        add_op(OPCODE_W'($urandom_range(7)), $urandom_range(4095), $urandom_range(7));
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (result_q.size() != 0)
      report_mismatch("missing results", 64'(result_q.size()), 64'd0);
    $display("Ran %0d transactions (%0d directed), %0d results checked.",
             n_accepted, n_directed, n_checked);
    $display("Observed %0d upcall raises and %0d poll-check pulses, %0d mismatches.",
             n_upcalls, n_polls, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
